// ----- hw/rtl/kse_pkg.sv -----
// Shared types, character codes and register indexes for the keyed signed decimal extractor.
// No dependencies; kse_cell, kse_window, kse_parse and the top level import this package.
package kse_pkg;

	localparam int KSE_MAX_KEY_BYTES = 16;

	// Configuration register indexes
	localparam logic [1:0] CFG_KEY_LOW    = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH   = 2'd1;
	localparam logic [1:0] CFG_KEY_LENGTH = 2'd2;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [30:0] MAG_LIMIT = 31'h7FFF_FFFF;
	localparam logic [3:0]  RADIX     = 4'd10;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_BLANKS = 3'd1,
		PH_SIGNED = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// Control from the parser to the row of window cells.
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

	// One result as produced by the parser, before the output register.
	typedef struct packed {
		logic        valid;
		logic        found;
		logic [31:0] number;
		logic        overflow;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

endpackage

// ----- hw/rtl/kse_cell.sv -----
// One cell of the recent-byte window: holds one byte and its valid flag, and compares the
// byte it is about to take against its key byte. Depends on kse_pkg.
module kse_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kse_pkg::win_ctrl_t  ctrl,
	input  logic [7:0]          prev_byte,
	input  logic                prev_valid,
	input  logic [7:0]          key_byte,
	input  logic                used,
	output logic [7:0]          byte_q,
	output logic                valid_q,
	output logic                hit
);
	import kse_pkg::*;

	// The compare looks at the value this cell holds after the shift.
	assign hit = !used || (prev_valid && (prev_byte == key_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= prev_byte;
		end
	end

endmodule

// ----- hw/rtl/kse_window.sv -----
// Row of window cells, newest byte in cell 0, with the masked key compare across the row.
// Depends on kse_pkg and kse_cell.
module kse_window #(
	parameter int MAX_KEY_BYTES = kse_pkg::KSE_MAX_KEY_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kse_pkg::win_ctrl_t  ctrl,
	input  logic [7:0]          text_byte,
	input  logic [127:0]        key_all,
	input  logic [4:0]          len_used,
	output logic                key_hit
);
	import kse_pkg::*;

	logic [7:0]               cell_byte  [MAX_KEY_BYTES];
	logic [MAX_KEY_BYTES-1:0] cell_valid;
	logic [MAX_KEY_BYTES-1:0] cell_hit;

	for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_cell
		localparam logic [4:0] POS = 5'(j);
		logic [7:0] prev_byte;
		logic       prev_valid;
		logic [3:0] key_idx;
		logic       used;

		if (j == 0) begin : g_head
			assign prev_byte  = text_byte;
			assign prev_valid = 1'b1;
		end else begin : g_link
			assign prev_byte  = cell_byte[j-1];
			assign prev_valid = cell_valid[j-1];
		end

		// The oldest byte in use lines up with key byte 0.
		assign used    = POS < len_used;
		assign key_idx = 4'(len_used - POS - 5'd1);

		kse_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_byte  (prev_byte),
			.prev_valid (prev_valid),
			.key_byte   (key_all[{key_idx, 3'b000} +: 8]),
			.used       (used),
			.byte_q     (cell_byte[j]),
			.valid_q    (cell_valid[j]),
			.hit        (cell_hit[j])
		);
	end

	assign key_hit = &cell_hit;

endmodule

// ----- hw/rtl/kse_parse.sv -----
// Phase sequencer and decimal accumulator: decides window shifts and clears, builds the signed
// value and forms the result. Depends on kse_pkg.
module kse_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          text_byte,
	input  logic                terminator,
	input  logic                key_hit,
	output kse_pkg::win_ctrl_t  ctrl,
	output kse_pkg::res_t       res
);
	import kse_pkg::*;

	phase_t      phase_q, phase_d;
	logic        neg_q;
	logic [30:0] mag_q;
	logic        sat_q;

	logic        digit;
	logic        blank;
	logic [34:0] acc_sum;
	logic        acc_over;
	logic [30:0] acc_mag;
	logic [31:0] mag_ext;
	logic        accumulate;

	assign digit = is_digit(text_byte);
	assign blank = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB);

	// Multiply by ten as two shifts and an add, then add the new digit.
	assign acc_sum  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
		+ 35'(text_byte[3:0]);
	assign acc_over = acc_sum > 35'(MAG_LIMIT);
	assign acc_mag  = acc_over ? MAG_LIMIT : acc_sum[30:0];
	assign mag_ext  = {1'b0, mag_q};

	assign accumulate = take && !terminator && digit
		&& ((phase_q == PH_BLANKS) || (phase_q == PH_SIGNED) || (phase_q == PH_DIGITS));

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			if (terminator) begin
				phase_d = PH_SEARCH;
			end else begin
				case (phase_q)
					PH_SEARCH: phase_d = key_hit ? PH_BLANKS : PH_SEARCH;
					PH_BLANKS: begin
						if (blank) begin
							phase_d = PH_BLANKS;
						end else if ((text_byte == CHAR_MINUS) || (text_byte == CHAR_PLUS)) begin
							phase_d = PH_SIGNED;
						end else if (digit) begin
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_SIGNED: phase_d = digit ? PH_DIGITS : PH_DONE;
					PH_DIGITS: phase_d = digit ? PH_DIGITS : PH_DONE;
					default:   phase_d = PH_DONE;
				endcase
			end
		end
	end

	// Outputs: window control and the result of this transfer
	always_comb begin
		ctrl.clear   = take && terminator;
		ctrl.shift   = take && !terminator && (phase_q == PH_SEARCH);
		res.valid    = 1'b0;
		res.found    = (phase_q == PH_DIGITS);
		if (take) begin
			if (terminator) begin
				res.valid = (phase_q != PH_DONE);
			end else begin
				case (phase_q)
					PH_BLANKS: res.valid = !blank && !digit
						&& (text_byte != CHAR_MINUS) && (text_byte != CHAR_PLUS);
					PH_SIGNED: res.valid = !digit;
					PH_DIGITS: res.valid = !digit;
					default:   res.valid = 1'b0;
				endcase
			end
		end
		if (res.found) begin
			res.number   = neg_q ? (~mag_ext + 32'd1) : mag_ext;
			res.overflow = sat_q;
		end else begin
			res.number   = 32'd0;
			res.overflow = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			neg_q   <= 1'b0;
			mag_q   <= 31'd0;
			sat_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (take && terminator) begin
				neg_q <= 1'b0;
				mag_q <= 31'd0;
				sat_q <= 1'b0;
			end else begin
				if (take && (phase_q == PH_BLANKS) && (text_byte == CHAR_MINUS)) begin
					neg_q <= 1'b1;
				end
				if (accumulate) begin
					mag_q <= acc_mag;
					sat_q <= sat_q | acc_over;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/keyed_signed_decimal_extract.sv -----
// Keyed signed decimal extractor, top level. Takes one text byte per clock cycle, with no
// bubbles, as long as the result register is free or being drained in the same cycle; the key
// compare across the window cells and the multiply-by-ten accumulate are combinational. A
// result appears on the result channel in the cycle after the transfer of the byte or
// terminator that decides it, and text_stall is high only while a result waits and is stalled.
// Configuration is accepted in every cycle (cfg_ready is always high) and must be written while
// no stream is in progress. Depends on kse_pkg, kse_window, kse_cell and kse_parse.
module keyed_signed_decimal_extract #(
	parameter int MAX_KEY_BYTES = kse_pkg::KSE_MAX_KEY_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  logic [7:0]         text_byte,
	input  logic               terminator,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               found,
	output logic signed [31:0] number,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import kse_pkg::*;

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  key_length_q;
	logic [4:0]  len_used;
	logic        take;
	logic        key_hit;
	win_ctrl_t   ctrl;
	res_t        res;
	logic        out_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= 64'd0;
			key_high_q   <= 64'd0;
			key_length_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_LOW:    key_low_q    <= cfg_data;
				CFG_KEY_HIGH:   key_high_q   <= cfg_data;
				CFG_KEY_LENGTH: key_length_q <= cfg_data[4:0];
				default:        ;
			endcase
		end
	end

	// A length of zero counts as one; lengths beyond the window are clipped to it.
	always_comb begin
		if (key_length_q == 5'd0) begin
			len_used = 5'd1;
		end else if (key_length_q > 5'(MAX_KEY_BYTES)) begin
			len_used = 5'(MAX_KEY_BYTES);
		end else begin
			len_used = key_length_q;
		end
	end

	assign text_stall = result_valid && result_stall;
	assign take       = text_valid && !text_stall;

	kse_window #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.text_byte (text_byte),
		.key_all   ({key_high_q, key_low_q}),
		.len_used  (len_used),
		.key_hit   (key_hit)
	);

	kse_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.text_byte  (text_byte),
		.terminator (terminator),
		.key_hit    (key_hit),
		.ctrl       (ctrl),
		.res        (res)
	);

	// The result register refills whenever it is empty or its transfer completes.
	assign out_load = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && res.valid) begin
			found    <= res.found;
			number   <= res.number;
			overflow <= res.overflow;
		end
	end

endmodule

// ----- hw/rtl/kse_checker.sv -----
// Port-level checks for the keyed signed decimal extractor, bound to the top level.
// Depends on keyed_signed_decimal_extract for the bind target only.
module kse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               text_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic               found,
	input logic signed [31:0] number,
	input logic               overflow
);

	// A stalled result stays on the port unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(number) && $stable(found)
			&& $stable(overflow))
		else $error("stalled result changed");

	// Input is held back only by a waiting, stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> result_valid && result_stall)
		else $error("text_stall without a stalled result");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> (number == 32'sd0) && !overflow)
		else $error("not-found result carries a value");

	a_overflow_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overflow |-> (number == 32'sh7FFF_FFFF) || (number == -32'sh7FFF_FFFF))
		else $error("overflow result not at the saturation limit");

	a_no_min_int: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> number != 32'sh8000_0000)
		else $error("result magnitude beyond the saturation limit");

endmodule

bind keyed_signed_decimal_extract kse_checker u_kse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_stall   (text_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.found        (found),
	.number       (number),
	.overflow     (overflow)
);
